// ===== hw/rtl/mif_pkg.sv =====
`timescale 1ns / 1ps
package mif_pkg;

   localparam int SQRT_STAGES = 32;
   localparam int DIV_STAGES  = 31;
   localparam int PIPE_LAT    = 2 * SQRT_STAGES + 2 * DIV_STAGES + 14;

   localparam int REQ_DATA_W = 344;
   localparam int RSP_DATA_W = 192;
   localparam int CSR_W      = 24;

   localparam logic [CSR_W-1:0] FRICTION_RESET = 24'd32768;
   localparam logic [CSR_W-1:0] STOP_RESET     = 24'd13107;

   localparam logic CSR_FRICTION = 1'b0;
   localparam logic CSR_STOP     = 1'b1;

   localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
   localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

   typedef struct packed {
      logic            fixed;
      logic            acc_zero;
      logic [19:0]     dt;
      logic [30:0]     maxs;
      logic [47:0]     tsq;
      logic [27:0]     fric;
      logic [2:0][31:0] pos;
      logic [2:0][31:0] v;
      logic [32:0]     len;
   } ctx_type;

   function automatic logic [31:0] sat32(input logic signed [63:0] x);
      logic [31:0] r;
      if (x > S32_MAX) begin
         r = 32'h7fff_ffff;
      end else if (x < S32_MIN) begin
         r = 32'h8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] mag32(input logic [31:0] x);
      return x[31] ? (~x + 32'd1) : x;
   endfunction

endpackage

// ===== hw/rtl/mif_sqrt.sv =====
`timescale 1ns / 1ps
module mif_sqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] x_in,
   output logic [32:0] r_out
);
   import mif_pkg::*;

   logic [63:0] x_ff [SQRT_STAGES];
   logic [63:0] r_ff [SQRT_STAGES];
   logic [63:0] xs [SQRT_STAGES+1];
   logic [63:0] rs [SQRT_STAGES+1];

   assign xs[0] = x_in;
   assign rs[0] = 64'd0;

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
      localparam logic [63:0] BIT = 64'd1 << (2 * (SQRT_STAGES - 1 - k));
      logic [63:0] trial;
      logic [63:0] x_in_k;
      logic [63:0] r_in_k;

      always_comb begin
         trial = rs[k] + BIT;
         if (xs[k] >= trial) begin
            x_in_k = xs[k] - trial;
            r_in_k = (rs[k] >> 1) + BIT;
         end else begin
            x_in_k = xs[k];
            r_in_k = rs[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k] <= x_in_k;
            r_ff[k] <= r_in_k;
         end
      end

      assign xs[k+1] = x_ff[k];
      assign rs[k+1] = r_ff[k];
   end

   assign r_out = rs[SQRT_STAGES][32:0];

endmodule

// ===== hw/rtl/mif_div.sv =====
`timescale 1ns / 1ps
module mif_div (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] num_in,
   input  logic [32:0] den_in,
   output logic [30:0] q_out
);
   import mif_pkg::*;

   logic [63:0] rem_ff [DIV_STAGES];
   logic [32:0] den_ff [DIV_STAGES];
   logic [30:0] q_ff [DIV_STAGES];
   logic [63:0] rems [DIV_STAGES+1];
   logic [32:0] dens [DIV_STAGES+1];
   logic [30:0] qs [DIV_STAGES+1];

   assign rems[0] = num_in;
   assign dens[0] = den_in;
   assign qs[0]   = 31'd0;

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      localparam int SH = DIV_STAGES - 1 - k;
      logic [63:0] dsh;
      logic [63:0] rem_in;
      logic [30:0] q_in;

      always_comb begin
         dsh = {31'd0, dens[k]} << SH;
         if (rems[k] >= dsh) begin
            rem_in = rems[k] - dsh;
            q_in   = {qs[k][29:0], 1'b1};
         end else begin
            rem_in = rems[k];
            q_in   = {qs[k][29:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= dens[k];
            q_ff[k]   <= q_in;
         end
      end

      assign rems[k+1] = rem_ff[k];
      assign dens[k+1] = den_ff[k];
      assign qs[k+1]   = q_ff[k];
   end

   assign q_out = qs[DIV_STAGES];

endmodule

// ===== hw/rtl/motion_integrator_friction_clamp.sv =====
`timescale 1ns / 1ps
// throughput: one word per cycle while the output skid buffer is empty, three speed lanes side by side
// the depth is set mostly by two 32-stage square root units and two banks of three 31-stage dividers
// synchronous reset empties the pipeline and output buffer and restores
// friction_accel to 0.5 and stop_threshold to 0.2
module motion_integrator_friction_clamp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // elapsed, max_speed, accel_x/y/z, speed_x/y/z, pos_x/y/z, zero pad
   input  logic [mif_pkg::REQ_DATA_W-1:0]    req_tdata,
   // fixed_mode
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // new_speed_x/y/z, new_pos_x/y/z
   output logic [mif_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_wr_en,
   input  logic                              csr_index,
   input  logic [mif_pkg::CSR_W-1:0]         csr_wdata
);
   import mif_pkg::*;

   logic [CSR_W-1:0] fa_ff;
   logic [CSR_W-1:0] st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fa_ff <= FRICTION_RESET;
         st_ff <= STOP_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FRICTION: fa_ff <= csr_wdata;
            CSR_STOP:     st_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   logic en;
   logic skid_vld_ff;
   logic out_vld_ff;
   logic [PIPE_LAT-1:0] vld_ff;

   assign en         = !skid_vld_ff;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], req_tvalid};
      end
   end

   // stage 1: accel*dt, friction step, threshold square
   ctx_type c1_in, c1_ff;
   logic signed [52:0] p1_in [3];
   logic signed [52:0] p1_ff [3];
   logic [43:0] fr_full;

   always_comb begin
      c1_in.fixed = req_tuser;
      c1_in.dt    = req_tdata[19:0];
      c1_in.maxs  = req_tdata[50:20];
      for (int i = 0; i < 3; i++) begin
         c1_in.v[i]   = req_tdata[147 + 32*i +: 32];
         c1_in.pos[i] = req_tdata[243 + 32*i +: 32];
         p1_in[i] = $signed(req_tdata[51 + 32*i +: 32]) * $signed({1'b0, req_tdata[19:0]});
      end
      c1_in.acc_zero = (req_tdata[146:51] == 96'd0);
      fr_full    = fa_ff * req_tdata[19:0];
      c1_in.fric = fr_full[43:16];
      c1_in.tsq  = st_ff * st_ff;
      c1_in.len  = 33'd0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff <= c1_in;
         for (int i = 0; i < 3; i++) begin
            p1_ff[i] <= p1_in[i];
         end
      end
   end

   // stage 2: speed update
   ctx_type c2_in, c2_ff;
   always_comb begin
      c2_in = c1_ff;
      for (int i = 0; i < 3; i++) begin
         if (!c1_ff.fixed) begin
            c2_in.v[i] = sat32(64'($signed(c1_ff.v[i])) + 64'(p1_ff[i] >>> 16));
         end
      end
   end

   // stage 3: squares, stage 4: sum
   ctx_type c3_ff, c4_ff;
   logic [63:0] sq3_ff [3];
   logic [63:0] sum4_ff;
   logic [31:0] m2 [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m2[i] = mag32(c2_ff.v[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c2_ff <= c2_in;
         c3_ff <= c2_ff;
         for (int i = 0; i < 3; i++) begin
            sq3_ff[i] <= m2[i] * m2[i];
         end
         c4_ff   <= c3_ff;
         sum4_ff <= sq3_ff[0] + sq3_ff[1] + sq3_ff[2];
      end
   end

   // first length
   logic [32:0] len1;
   ctx_type da_ff [SQRT_STAGES];

   mif_sqrt u_sqrt_a (
      .clock (clock),
      .en    (en),
      .x_in  (sum4_ff),
      .r_out (len1)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         da_ff[0] <= c4_ff;
         for (int k = 1; k < SQRT_STAGES; k++) begin
            da_ff[k] <= da_ff[k-1];
         end
      end
   end

   // stage 5: friction numerators
   ctx_type c5_in, c5_ff;
   logic [63:0] num5_ff [3];
   logic [31:0] m5 [3];

   always_comb begin
      c5_in     = da_ff[SQRT_STAGES-1];
      c5_in.len = len1;
      for (int i = 0; i < 3; i++) begin
         m5[i] = mag32(c5_in.v[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c5_ff <= c5_in;
         for (int i = 0; i < 3; i++) begin
            num5_ff[i] <= 64'(m5[i]) * 64'(c5_in.fric);
         end
      end
   end

   logic [30:0] qf [3];
   ctx_type db_ff [DIV_STAGES];

   for (genvar i = 0; i < 3; i++) begin : g_fdiv
      mif_div u_div (
         .clock  (clock),
         .en     (en),
         .num_in (num5_ff[i]),
         .den_in (c5_ff.len),
         .q_out  (qf[i])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         db_ff[0] <= c5_ff;
         for (int k = 1; k < DIV_STAGES; k++) begin
            db_ff[k] <= db_ff[k-1];
         end
      end
   end

   // stage 6: apply friction
   ctx_type c6_in, c6_ff, c7_ff, c8_ff;
   logic signed [63:0] qx6 [3];

   always_comb begin
      c6_in = db_ff[DIV_STAGES-1];
      for (int i = 0; i < 3; i++) begin
         qx6[i] = $signed({33'd0, qf[i]});
         if (!c6_in.fixed && c6_in.len != 33'd0) begin
            if (c6_in.v[i][31]) begin
               c6_in.v[i] = sat32(64'($signed(c6_in.v[i])) + qx6[i]);
            end else begin
               c6_in.v[i] = sat32(64'($signed(c6_in.v[i])) - qx6[i]);
            end
         end
      end
   end

   logic [63:0] sq7_ff [3];
   logic [63:0] sum8_ff;
   logic [31:0] m6 [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m6[i] = mag32(c6_ff.v[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c6_ff <= c6_in;
         c7_ff <= c6_ff;
         for (int i = 0; i < 3; i++) begin
            sq7_ff[i] <= m6[i] * m6[i];
         end
         c8_ff   <= c7_ff;
         sum8_ff <= sq7_ff[0] + sq7_ff[1] + sq7_ff[2];
      end
   end

   // second length
   logic [32:0] len2;
   ctx_type dc_ff [SQRT_STAGES];

   mif_sqrt u_sqrt_b (
      .clock (clock),
      .en    (en),
      .x_in  (sum8_ff),
      .r_out (len2)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         dc_ff[0] <= c8_ff;
         for (int k = 1; k < SQRT_STAGES; k++) begin
            dc_ff[k] <= dc_ff[k-1];
         end
      end
   end

   // stage 9: clamp numerators
   ctx_type c9_in, c9_ff;
   logic [63:0] num9_ff [3];
   logic [31:0] m9 [3];

   always_comb begin
      c9_in     = dc_ff[SQRT_STAGES-1];
      c9_in.len = len2;
      for (int i = 0; i < 3; i++) begin
         m9[i] = mag32(c9_in.v[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c9_ff <= c9_in;
         for (int i = 0; i < 3; i++) begin
            num9_ff[i] <= 64'(m9[i]) * 64'(c9_in.maxs);
         end
      end
   end

   logic [30:0] qc [3];
   ctx_type dd_ff [DIV_STAGES];

   for (genvar i = 0; i < 3; i++) begin : g_cdiv
      mif_div u_div (
         .clock  (clock),
         .en     (en),
         .num_in (num9_ff[i]),
         .den_in (c9_ff.len),
         .q_out  (qc[i])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dd_ff[0] <= c9_ff;
         for (int k = 1; k < DIV_STAGES; k++) begin
            dd_ff[k] <= dd_ff[k-1];
         end
      end
   end

   // stage 10: speed clamp
   ctx_type c10_in, c10_ff, c11_ff, c12_ff;
   logic [31:0] qz10 [3];

   always_comb begin
      c10_in = dd_ff[DIV_STAGES-1];
      for (int i = 0; i < 3; i++) begin
         qz10[i] = {1'b0, qc[i]};
         if (!c10_in.fixed && c10_in.len >= {2'b00, c10_in.maxs}) begin
            if (c10_in.len == 33'd0) begin
               c10_in.v[i] = 32'd0;
            end else if (c10_in.v[i][31]) begin
               c10_in.v[i] = ~qz10[i] + 32'd1;
            end else begin
               c10_in.v[i] = qz10[i];
            end
         end
      end
   end

   // stage 11: squares, stage 12: stop test
   logic [63:0] sq11_ff [3];
   logic [31:0] m10 [3];
   logic [63:0] sum12;
   logic z12_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m10[i] = mag32(c10_ff.v[i]);
      end
      sum12 = sq11_ff[0] + sq11_ff[1] + sq11_ff[2];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c10_ff <= c10_in;
         c11_ff <= c10_ff;
         for (int i = 0; i < 3; i++) begin
            sq11_ff[i] <= m10[i] * m10[i];
         end
         c12_ff <= c11_ff;
         z12_ff <= !c11_ff.fixed && c11_ff.acc_zero && (sum12 < {16'd0, c11_ff.tsq});
      end
   end

   // stage 13: stop and position step, stage 14: position update
   ctx_type c13_in, c13_ff;
   logic signed [52:0] p13_in [3];
   logic signed [52:0] p13_ff [3];
   logic [RSP_DATA_W-1:0] d14_in, d14_ff;

   always_comb begin
      c13_in = c12_ff;
      for (int i = 0; i < 3; i++) begin
         if (z12_ff) begin
            c13_in.v[i] = 32'd0;
         end
         p13_in[i] = $signed(c13_in.v[i]) * $signed({1'b0, c13_in.dt});
      end
      for (int i = 0; i < 3; i++) begin
         d14_in[32*i +: 32]      = c13_ff.v[i];
         d14_in[96 + 32*i +: 32] = sat32(64'($signed(c13_ff.pos[i])) + 64'(p13_ff[i] >>> 16));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c13_ff <= c13_in;
         for (int i = 0; i < 3; i++) begin
            p13_ff[i] <= p13_in[i];
         end
         d14_ff <= d14_in;
      end
   end

   // output register with skid
   logic [RSP_DATA_W-1:0] out_ff;
   logic [RSP_DATA_W-1:0] skid_ff;
   logic pop;
   logic push;

   assign pop  = out_vld_ff && rsp_tready;
   assign push = en && vld_ff[PIPE_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (pop) begin
            skid_vld_ff <= 1'b0;
         end
      end else if (push) begin
         if (out_vld_ff && !pop) begin
            skid_vld_ff <= 1'b1;
         end else begin
            out_vld_ff <= 1'b1;
         end
      end else if (pop) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (out_vld_ff && !pop) begin
            skid_ff <= d14_ff;
         end else begin
            out_ff <= d14_ff;
         end
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid word without output word");

   a_reset_flush: assert property (@(posedge clock)
      reset |=> (vld_ff == '0) && !out_vld_ff && !skid_vld_ff)
      else $error("pipeline not empty after reset");

   a_tail_held: assert property (@(posedge clock) disable iff (reset)
      vld_ff[PIPE_LAT-1] && !en |=> vld_ff[PIPE_LAT-1])
      else $error("stalled tail word lost");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import mif_pkg::*;

   typedef struct packed {
      logic             fixed;
      logic [19:0]      dt;
      logic [30:0]      maxs;
      logic [2:0][31:0] acc;
      logic [2:0][31:0] spd;
      logic [2:0][31:0] pos;
   } entity_t;

   typedef struct packed {
      logic [2:0][31:0] spd;
      logic [2:0][31:0] pos;
   } motion_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_wr_en = 1'b0;
   logic csr_index = CSR_FRICTION;
   logic [CSR_W-1:0] csr_wdata = '0;
   logic req_taken = 1'b0;

   motion_integrator_friction_clamp DUT (.*);

   entity_t pending_q[$];
   motion_t motion_q[$];
   logic [23:0] friction_reg, stop_reg;
   int errors = 0;
   int send_idle = 0, recv_stall = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic signed [63:0] sat(input logic signed [63:0] x);
      if (x > S32_MAX) return S32_MAX;
      if (x < S32_MIN) return S32_MIN;
      return x;
   endfunction

   function automatic logic [63:0] root64(input logic [63:0] x);
      logic [63:0] r, b;
      r = '0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] len3(input logic signed [63:0] s[3]);
      logic [63:0] sum, a;
      sum = '0;
      for (int i = 0; i < 3; i++) begin
         a = s[i] < 0 ? -s[i] : s[i];
         sum = sum + a * a;
      end
      return root64(sum);
   endfunction

   function automatic logic signed [63:0] scale(input logic signed [63:0] v,
         input logic [63:0] k, input logic [63:0] d);
      logic [63:0] q, a;
      a = v < 0 ? -v : v;
      q = (a * k) / d;
      return v < 0 ? -$signed(q) : $signed(q);
   endfunction

   function automatic motion_t integrate(input entity_t e);
      logic signed [63:0] s[3], t[3];
      logic signed [63:0] dt;
      logic signed [63:0] np;
      logic [63:0] f, len;
      logic acc_zero;
      motion_t m;
      dt = {44'd0, e.dt};
      for (int i = 0; i < 3; i++) s[i] = $signed(e.spd[i]);
      if (!e.fixed) begin
         f = ({40'd0, friction_reg} * e.dt) >> 16;
         acc_zero = e.acc == '0;
         for (int i = 0; i < 3; i++)
            s[i] = sat(s[i] + (($signed({{32{e.acc[i][31]}}, e.acc[i]}) * dt) >>> 16));
         len = len3(s);
         if (len != 0) begin
            for (int i = 0; i < 3; i++) t[i] = scale(s[i], f, len);
            for (int i = 0; i < 3; i++) s[i] = sat(s[i] - t[i]);
         end
         len = len3(s);
         if (len >= e.maxs) begin
            for (int i = 0; i < 3; i++)
               s[i] = len == 0 ? 64'sd0 : sat(scale(s[i], {33'd0, e.maxs}, len));
         end
         if (acc_zero && len3(s) < stop_reg)
            for (int i = 0; i < 3; i++) s[i] = 64'sd0;
      end
      for (int i = 0; i < 3; i++) begin
         m.spd[i] = s[i][31:0];
         np = sat($signed({{32{e.pos[i][31]}}, e.pos[i]}) + ((s[i] * dt) >>> 16));
         m.pos[i] = np[31:0];
      end
      return m;
   endfunction

   always @(posedge clock) begin
      req_taken <= req_tvalid && req_tready;
   end

   // driver
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_taken)) begin
         if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
            entity_t e;
            e = pending_q.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= e.fixed;
            req_tdata <= {5'd0, e.pos[2], e.pos[1], e.pos[0], e.spd[2], e.spd[1],
                          e.spd[0], e.acc[2], e.acc[1], e.acc[0], e.maxs, e.dt};
            motion_q.push_back(integrate(e));
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= !reset && ($urandom_range(99) >= recv_stall);
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
   endtask

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (motion_q.size() == 0) begin
            report("unexpected word", rsp_tdata[31:0], 32'd0);
         end else begin
            motion_t w;
            w = motion_q.pop_front();
            for (int i = 0; i < 3; i++) begin
               if (rsp_tdata[32*i +: 32] !== w.spd[i])
                  report($sformatf("speed %0d", i), rsp_tdata[32*i +: 32], w.spd[i]);
               if (rsp_tdata[96+32*i +: 32] !== w.pos[i])
                  report($sformatf("pos %0d", i), rsp_tdata[96+32*i +: 32], w.pos[i]);
            end
         end
      end
   end

   function automatic logic [31:0] pick32();
      case ($urandom_range(7))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'd0;
         3: return $urandom_range(65536 * 4) - 32'd131072;
         4: return $urandom_range(65536 * 200) - 32'd6553600;
         default: return $urandom;
      endcase
   endfunction

   function automatic entity_t rand_entity();
      entity_t e;
      e.fixed = $urandom_range(7) == 0;
      case ($urandom_range(3))
         0: e.dt = 20'($urandom);
         1: e.dt = 20'hfffff;
         default: e.dt = 20'($urandom_range(8192));
      endcase
      case ($urandom_range(3))
         0: e.maxs = 31'($urandom);
         1: e.maxs = 31'($urandom_range(65536 * 4));
         default: e.maxs = 31'($urandom_range(65536 * 100));
      endcase
      if ($urandom_range(3) == 0) e.acc = '0;
      else for (int i = 0; i < 3; i++) e.acc[i] = pick32();
      for (int i = 0; i < 3; i++) begin
         e.spd[i] = pick32();
         e.pos[i] = pick32();
      end
      return e;
   endfunction

   task automatic csr_write(input logic idx, input logic [23:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_FRICTION) friction_reg = val;
      else stop_reg = val;
   endtask

   task automatic drain();
      wait (pending_q.size() == 0 && motion_q.size() == 0);
      repeat (PIPE_LAT + 20) @(negedge clock);
   endtask

   initial begin
      entity_t e;
      logic [23:0] fr[4], st[4];
      int idle_s[4], idle_r[4];
      fr = '{24'd32768, 24'hffffff, 24'd0, 24'd0};
      st = '{24'd13107, 24'd0, 24'hffffff, 24'd0};
      idle_s = '{0, 51, 0, 12};
      idle_r = '{0, 0, 51, 12};
      friction_reg = FRICTION_RESET;
      stop_reg = STOP_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: zero speed, fixed mode, saturation, clamp, stop
      e = '0; pending_q.push_back(e);
      e.maxs = 31'h7fffffff; pending_q.push_back(e);
      e = '0; e.fixed = 1'b1; e.dt = 20'hfffff;
      e.spd = {32'h7fffffff, 32'h80000000, 32'h00010000};
      e.pos = {32'h7fffffff, 32'h80000000, 32'd0}; pending_q.push_back(e);
      e.fixed = 1'b0; e.maxs = 31'h7fffffff; pending_q.push_back(e);
      e.acc = {32'h7fffffff, 32'h80000000, 32'h7fffffff}; pending_q.push_back(e);
      e = '0; e.dt = 20'h10000; e.maxs = 31'h10000;
      e.spd = {32'd0, 32'd0, 32'h50000}; pending_q.push_back(e);
      e.spd = {32'd0, 32'd0, 32'd3000}; e.maxs = 31'h7fffffff; pending_q.push_back(e);
      e.acc = {32'd0, 32'd0, 32'd1}; pending_q.push_back(e);
      e = '0; e.dt = 20'h8000; e.spd = {32'd100, 32'hffffff00, 32'd5};
      e.maxs = 31'd0; pending_q.push_back(e);
      for (int i = 0; i < 12; i++) pending_q.push_back(rand_entity());
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         csr_write(CSR_FRICTION, ph == 3 ? 24'($urandom) : fr[ph]);
         csr_write(CSR_STOP, ph == 3 ? 24'($urandom_range(200000)) : st[ph]);
         for (int k = 0; k < 4; k++) begin
            send_idle = idle_s[k];
            recv_stall = idle_r[k];
            for (int i = 0; i < 78; i++) pending_q.push_back(rand_entity());
            wait (pending_q.size() == 0);
         end
         send_idle = 0;
         recv_stall = 0;
         drain();
      end
      if (errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("testbench NOT OK");
      $finish;
   end
endmodule
